// ----- hdl/ptb_pkg.sv -----
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types, codes and widths for the periodic timer bank.
// ----------------------------------------------------------------------------
package ptb_pkg;

  localparam int NUM_TIMERS_DEF = 8;
  localparam int TIMEOUT_W      = 32;
  localparam int INDEX_W        = 8;
  localparam int SLOT_W         = 3;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_REGISTER = 2'd1,
    OP_START    = 2'd2,
    OP_STOP     = 2'd3
  } op_t;

  localparam logic [1:0] KIND_REGISTER  = 2'd0;
  localparam logic [1:0] KIND_STARTSTOP = 2'd1;
  localparam logic [1:0] KIND_EXPIRY    = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BADINDEX = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_t;

  // One pending result, waiting to be handed to the output register.
  typedef struct packed {
    logic [1:0]        event_kind;
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
  } result_t;

  // What the shared tick unit tells the sequencer about one slot.
  typedef struct packed {
    logic [TIMEOUT_W-1:0] wr_value;
    logic                 expire;
  } tick_res_t;

endpackage

// ----- hdl/ptb_if.sv -----
// ----------------------------------------------------------------------------
// ptb_cmd_if / ptb_evt_if
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
interface ptb_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic [ptb_pkg::TIMEOUT_W-1:0] timeout_value;
  logic [ptb_pkg::INDEX_W-1:0]   timer_index;

  modport source (output valid, output op, output timeout_value, output timer_index,
                  input ready);
  modport sink   (input valid, input op, input timeout_value, input timer_index,
                  output ready);
endinterface

interface ptb_evt_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 event_kind;
  logic [1:0]                 status;
  logic [ptb_pkg::SLOT_W-1:0] slot;
  logic                       last;

  modport source (output valid, output event_kind, output status, output slot,
                  output last, input ready);
  modport sink   (input valid, input event_kind, input status, input slot,
                  input last, output ready);
endinterface

// ----- hdl/periodic_timer_bank.sv -----
// ----------------------------------------------------------------------------
// periodic_timer_bank
// A bank of periodic timers with register, start, stop and tick operations.
// ----------------------------------------------------------------------------
//
//   Channel  Role   Word carries
//   -------  -----  -------------------------------------------------------
//   cmd      sink   op, timeout_value, timer_index
//   evt      source event_kind, status, slot, last
//
// Register, start and stop are taken in the accept cycle, which updates
// the state, and then in the flush state, which moves the reply into the
// output register. A tick scans the registered timers, one slot per cycle
// through the single decrement unit; with none, it gives no result.
// A stalled result side holds the scan on the slot whose expiry cannot move.
// Reset clears the registration count and flags; slot memories need no clear.
// ----------------------------------------------------------------------------
module periodic_timer_bank #(
  parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
  input logic       clk,
  input logic       rst,
  ptb_cmd_if.sink   cmd,
  ptb_evt_if.source evt
);

  localparam int IDXW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNTW = $clog2(NUM_TIMERS + 1);

  // Sequencer state and scan position.
  ptb_pkg::state_t state;
  ptb_pkg::state_t state_next;
  logic [IDXW-1:0] idx;
  logic [IDXW-1:0] idx_next;

  // Number of registered slots and the running flag of every slot.
  logic [CNTW-1:0]       reg_count;
  logic [NUM_TIMERS-1:0] running;

  // One result is held back so that the final word of an operation can be
  // marked as last once it is known that no further expiry follows.
  logic              held_valid;
  ptb_pkg::result_t  held;
  ptb_pkg::result_t  reply;

  // Output register.
  logic                       out_valid;
  logic [1:0]                 out_kind;
  logic [1:0]                 out_status;
  logic [ptb_pkg::SLOT_W-1:0] out_slot;
  logic                       out_last;

  // Handshake and control.
  logic accept;
  logic out_free;
  logic full;
  logic bad_index;
  logic last_slot;
  logic step;
  logic push;
  logic push_last;
  logic do_register;
  logic do_startstop;

  // Slot memories and the shared unit.
  logic                          cnt_wr_en;
  logic [IDXW-1:0]               cnt_wr_addr;
  logic [ptb_pkg::TIMEOUT_W-1:0] cnt_wr_data;
  logic [ptb_pkg::TIMEOUT_W-1:0] cnt_rd_data;
  logic [ptb_pkg::TIMEOUT_W-1:0] tmo_rd_data;
  ptb_pkg::tick_res_t            unit_res;

  assign out_free  = !out_valid || evt.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign full      = (reg_count == CNTW'(NUM_TIMERS));
  assign bad_index = (cmd.timer_index >= ptb_pkg::INDEX_W'(NUM_TIMERS));
  assign last_slot = (CNTW'(idx) == (reg_count - CNTW'(1)));

  assign do_register  = accept && (cmd.op == ptb_pkg::OP_REGISTER) && !full;
  assign do_startstop = accept && ((cmd.op == ptb_pkg::OP_START) ||
                                   (cmd.op == ptb_pkg::OP_STOP)) && !bad_index;

  // Reply word for register, start and stop.
  always_comb begin
    if (cmd.op == ptb_pkg::OP_REGISTER) begin
      reply.event_kind = ptb_pkg::KIND_REGISTER;
      reply.status     = full ? ptb_pkg::ST_FULL : ptb_pkg::ST_OK;
      reply.slot       = full ? '0 : ptb_pkg::SLOT_W'(reg_count);
    end else begin
      reply.event_kind = ptb_pkg::KIND_STARTSTOP;
      reply.status     = bad_index ? ptb_pkg::ST_BADINDEX : ptb_pkg::ST_OK;
      reply.slot       = '0;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ptb_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd.op == ptb_pkg::OP_TICK) begin
            state_next = (reg_count != '0) ? ptb_pkg::S_SCAN : ptb_pkg::S_IDLE;
          end else begin
            state_next = ptb_pkg::S_FLUSH;
          end
        end
      end
      ptb_pkg::S_SCAN: begin
        if (step && last_slot) begin
          state_next = ptb_pkg::S_FLUSH;
        end
      end
      ptb_pkg::S_FLUSH: begin
        if (!held_valid || out_free) begin
          state_next = ptb_pkg::S_IDLE;
        end
      end
      default: state_next = ptb_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    cmd.ready = 1'b0;
    step      = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    idx_next  = idx;
    case (state)
      ptb_pkg::S_IDLE: begin
        cmd.ready = 1'b1;
        idx_next  = '0;
      end
      ptb_pkg::S_SCAN: begin
        // An expiry pushes out the held word first, which needs room.
        step = !(unit_res.expire && held_valid) || out_free;
        push = unit_res.expire && held_valid && out_free;
        if (step && !last_slot) begin
          idx_next = idx + IDXW'(1);
        end
      end
      ptb_pkg::S_FLUSH: begin
        push      = held_valid && out_free;
        push_last = 1'b1;
      end
      default: begin
        cmd.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
  end

  // Registration count and running flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_count <= '0;
      running   <= '0;
    end else begin
      if (do_register) begin
        reg_count                  <= reg_count + CNTW'(1);
        running[reg_count[IDXW-1:0]] <= 1'b0;
      end
      if (do_startstop) begin
        running[cmd.timer_index[IDXW-1:0]] <= (cmd.op == ptb_pkg::OP_START);
      end
    end
  end

  // Held-back result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if ((state == ptb_pkg::S_IDLE) && accept &&
                 (cmd.op != ptb_pkg::OP_TICK)) begin
      held_valid <= 1'b1;
    end else if ((state == ptb_pkg::S_SCAN) && step && unit_res.expire) begin
      held_valid <= 1'b1;
    end else if ((state == ptb_pkg::S_FLUSH) && push) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ptb_pkg::S_IDLE) && accept) begin
      held <= reply;
    end else if ((state == ptb_pkg::S_SCAN) && step && unit_res.expire) begin
      held.event_kind <= ptb_pkg::KIND_EXPIRY;
      held.status     <= ptb_pkg::ST_OK;
      held.slot       <= ptb_pkg::SLOT_W'(idx);
    end
  end

  // Output register: loads when it is empty or while the previous word leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= push || (out_valid && !evt.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_kind   <= held.event_kind;
      out_status <= held.status;
      out_slot   <= held.slot;
      out_last   <= push_last;
    end
  end

  assign evt.valid      = out_valid;
  assign evt.event_kind = out_kind;
  assign evt.status     = out_status;
  assign evt.slot       = out_slot;
  assign evt.last       = out_last;

  // The count memory is written by register and by each scan step; the
  // timeout memory by register alone. Both read the slot the scan visits next.
  always_comb begin
    if (do_register) begin
      cnt_wr_en   = 1'b1;
      cnt_wr_addr = reg_count[IDXW-1:0];
      cnt_wr_data = cmd.timeout_value;
    end else begin
      cnt_wr_en   = (state == ptb_pkg::S_SCAN) && step;
      cnt_wr_addr = idx;
      cnt_wr_data = unit_res.wr_value;
    end
  end

  ptb_ram #(
    .DEPTH (NUM_TIMERS),
    .WIDTH (ptb_pkg::TIMEOUT_W)
  ) u_count_mem (
    .clk     (clk),
    .wr_en   (cnt_wr_en),
    .wr_addr (cnt_wr_addr),
    .wr_data (cnt_wr_data),
    .rd_addr (idx_next),
    .rd_data (cnt_rd_data)
  );

  ptb_ram #(
    .DEPTH (NUM_TIMERS),
    .WIDTH (ptb_pkg::TIMEOUT_W)
  ) u_timeout_mem (
    .clk     (clk),
    .wr_en   (do_register),
    .wr_addr (reg_count[IDXW-1:0]),
    .wr_data (cmd.timeout_value),
    .rd_addr (idx_next),
    .rd_data (tmo_rd_data)
  );

  ptb_tick_unit u_tick_unit (
    .count   (cnt_rd_data),
    .timeout (tmo_rd_data),
    .running (running[idx]),
    .res     (unit_res)
  );

endmodule

// ----- hdl/ptb_ram.sv -----
// ----------------------------------------------------------------------------
// ptb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ptb_ram #(
  parameter int DEPTH = ptb_pkg::NUM_TIMERS_DEF,
  parameter int WIDTH = ptb_pkg::TIMEOUT_W,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/ptb_tick_unit.sv -----
// ----------------------------------------------------------------------------
// ptb_tick_unit
// Shared decrement and zero test, applied to one slot per cycle unless the scan is held.
// ----------------------------------------------------------------------------
module ptb_tick_unit (
  input  logic [ptb_pkg::TIMEOUT_W-1:0] count,
  input  logic [ptb_pkg::TIMEOUT_W-1:0] timeout,
  input  logic                          running,
  output ptb_pkg::tick_res_t            res
);

  logic [ptb_pkg::TIMEOUT_W-1:0] dec;

  always_comb begin
    // A stopped timer keeps its count; a running one saturates at zero.
    if (running && (count != '0)) begin
      dec = count - ptb_pkg::TIMEOUT_W'(1);
    end else begin
      dec = count;
    end
    res.expire   = (dec == '0);
    res.wr_value = res.expire ? timeout : dec;
  end

endmodule

// ----- verif/tb_periodic_timer_bank.sv -----
// ----------------------------------------------------------------------------
// tb_periodic_timer_bank
// Self-checking bench for the periodic timer bank.
// A cycle-free mirror of the bank predicts the result words of every
// accepted operation word. Each result word is checked in order, field by
// field. A short directed sequence exercises the error and corner paths.
// Random traffic then runs under four idling patterns on the two channels.
// ----------------------------------------------------------------------------
module tb_periodic_timer_bank;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BANK_SIZE    = ptb_pkg::NUM_TIMERS_DEF;
  localparam int ITEMS_PER_PH = 50;   // random words in each idling phase
  localparam int STALL_LIMIT  = 5000; // cycles with no word moving on either side
  localparam int SETTLE_CYC   = 40;   // wait after draining for any stray result word

  // --------------------------------------------------------------------------
  // Mirror of the bank. It replays each accepted operation on its own copy of
  // the slot state and queues the result words that operation must produce.
  // --------------------------------------------------------------------------
  class timer_bank_mirror;
    logic [ptb_pkg::TIMEOUT_W-1:0] period_q [BANK_SIZE];
    logic [ptb_pkg::TIMEOUT_W-1:0] remain_q [BANK_SIZE];
    bit                            armed    [BANK_SIZE];
    int unsigned                   claimed;

    // Each entry is {event_kind, status, slot, last}.
    logic [7:0] due_words [$];

    int errors;
    int ticks_seen;
    int expiries_seen;
    int full_seen;
    int bad_index_seen;

    function new();
      claimed = 0;
      foreach (armed[i]) begin
        armed[i]    = 1'b0;
        remain_q[i] = '0;
        period_q[i] = '0;
      end
    endfunction

    function void apply_op(ptb_pkg::op_t op, logic [ptb_pkg::TIMEOUT_W-1:0] tmo,
                           logic [ptb_pkg::INDEX_W-1:0] idx);
      int last_zero;
      case (op)
        ptb_pkg::OP_REGISTER: begin
          if (claimed >= BANK_SIZE) begin
            due_words.push_back({ptb_pkg::KIND_REGISTER, ptb_pkg::ST_FULL, 3'd0, 1'b1});
            full_seen++;
          end else begin
            period_q[claimed] = tmo;
            remain_q[claimed] = tmo;
            armed[claimed]    = 1'b0;
            due_words.push_back({ptb_pkg::KIND_REGISTER, ptb_pkg::ST_OK,
                                 claimed[ptb_pkg::SLOT_W-1:0], 1'b1});
            claimed++;
          end
        end
        ptb_pkg::OP_START, ptb_pkg::OP_STOP: begin
          if (idx >= BANK_SIZE) begin
            due_words.push_back({ptb_pkg::KIND_STARTSTOP, ptb_pkg::ST_BADINDEX,
                                 3'd0, 1'b1});
            bad_index_seen++;
          end else begin
            // Unregistered slots keep their flag too; registering clears it.
            armed[idx] = (op == ptb_pkg::OP_START);
            due_words.push_back({ptb_pkg::KIND_STARTSTOP, ptb_pkg::ST_OK, 3'd0, 1'b1});
          end
        end
        default: begin
          // Tick: decrement the running counts first, then every slot at zero
          // expires in slot order, whether it is running or not.
          ticks_seen++;
          last_zero = -1;
          for (int i = 0; i < claimed; i++) begin
            if (armed[i] && remain_q[i] != 0) remain_q[i] = remain_q[i] - 1;
            if (remain_q[i] == 0) last_zero = i;
          end
          for (int i = 0; i < claimed; i++) begin
            if (remain_q[i] == 0) begin
              due_words.push_back({ptb_pkg::KIND_EXPIRY, ptb_pkg::ST_OK,
                                   i[ptb_pkg::SLOT_W-1:0], i == last_zero});
              remain_q[i] = period_q[i];
              expiries_seen++;
            end
          end
        end
      endcase
    endfunction

    function void report(string field, logic [2:0] want, logic [2:0] got);
      $display("%0t ns: result word %s mismatch, expected %0d, actual %0d",
               $time, field, want, got);
      errors++;
    endfunction

    function void check_word(logic [1:0] kind, logic [1:0] status,
                             logic [ptb_pkg::SLOT_W-1:0] slot, logic last);
      logic [7:0] want;
      if (due_words.size() == 0) begin
        $display("%0t ns: result word with none expected, actual kind %0d status %0d",
                 $time, kind, status);
        $display("%0t ns: unexpected word continues, actual slot %0d last %0d",
                 $time, slot, last);
        errors++;
        return;
      end
      want = due_words.pop_front();
      if (kind   !== want[7:6]) report("event_kind", want[7:6], kind);
      if (status !== want[5:4]) report("status", want[5:4], status);
      if (slot   !== want[3:1]) report("slot", want[3:1], slot);
      if (last   !== want[0])   report("last", want[0], last);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself.
  // --------------------------------------------------------------------------
  logic clk;
  logic rst = 1'b1;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  ptb_cmd_if cmd_ch ();
  ptb_evt_if evt_ch ();

  periodic_timer_bank i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .evt (evt_ch)
  );

  timer_bank_mirror book;

  // Idling odds in percent, changed by the main sequence between phases.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          words_sent     = 0;
  int          words_checked  = 0;
  int          idle_cycles    = 0;

  // --------------------------------------------------------------------------
  // Result side. Ready changes on the falling edge with the current stall
  // odds, and a word is taken at the rising edge when valid and ready meet.
  // --------------------------------------------------------------------------
  initial evt_ch.ready = 1'b0;

  always @(negedge clk) begin
    evt_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && evt_ch.valid && evt_ch.ready) begin
      book.check_word(evt_ch.event_kind, evt_ch.status, evt_ch.slot, evt_ch.last);
      words_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog. A healthy bank moves a word on one side or the other well
  // within this many cycles, even with a full-bank tick facing long stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (evt_ch.valid && evt_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("periodic_timer_bank test failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Operation side. Called at a falling edge; it first idles, with valid low,
  // while a random draw falls under the idle odds, then holds the word until
  // the bank accepts it and returns at the next falling edge with valid still
  // high, so back-to-back words leave no bubble.
  // --------------------------------------------------------------------------
  task automatic send_op(ptb_pkg::op_t op, logic [ptb_pkg::TIMEOUT_W-1:0] tmo,
                         logic [ptb_pkg::INDEX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid         = 1'b1;
    cmd_ch.op            = op;
    cmd_ch.timeout_value = tmo;
    cmd_ch.timer_index   = idx;
    do @(posedge clk); while (!cmd_ch.ready);
    book.apply_op(op, tmo, idx);
    words_sent++;
    @(negedge clk);
  endtask

  // Random word: ticks dominate so that the timers actually count down, and
  // most start or stop indexes land inside the bank.
  task automatic send_random_op();
    int unsigned                 pick;
    ptb_pkg::op_t                op;
    logic [ptb_pkg::INDEX_W-1:0] idx;
    pick = $urandom_range(99);
    if (pick < 45)      op = ptb_pkg::OP_TICK;
    else if (pick < 65) op = ptb_pkg::OP_START;
    else if (pick < 82) op = ptb_pkg::OP_STOP;
    else                op = ptb_pkg::OP_REGISTER;
    if ($urandom_range(99) < 85) idx = ptb_pkg::INDEX_W'($urandom_range(BANK_SIZE - 1));
    else                         idx = ptb_pkg::INDEX_W'($urandom_range(255));
    send_op(op, $urandom, idx);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    book                 = new();
    cmd_ch.valid         = 1'b0;
    cmd_ch.op            = ptb_pkg::OP_TICK;
    cmd_ch.timeout_value = '0;
    cmd_ch.timer_index   = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, with neither side idling.
    // An empty bank gives no result on a tick.
    send_op(ptb_pkg::OP_TICK, 32'd0, 8'd0);
    // Start and stop on a slot that is not registered yet still reply ok.
    send_op(ptb_pkg::OP_START, 32'd0, 8'd3);
    send_op(ptb_pkg::OP_STOP, 32'd0, 8'd3);
    // Indexes at and far beyond the bank size are rejected.
    send_op(ptb_pkg::OP_START, 32'd0, BANK_SIZE[ptb_pkg::INDEX_W-1:0]);
    send_op(ptb_pkg::OP_STOP, 32'd0, 8'hFF);
    // Slot 1 is armed before it exists; registering it must disarm it.
    send_op(ptb_pkg::OP_START, 32'd0, 8'd1);
    // A zero timeout keeps slot 0 expiring on every tick, even while stopped.
    send_op(ptb_pkg::OP_REGISTER, 32'd0, 8'd0);
    send_op(ptb_pkg::OP_REGISTER, 32'd1, 8'd0);
    send_op(ptb_pkg::OP_TICK, 32'd0, 8'd0);
    // Once slot 1 runs, the next tick brings two expiries in slot order.
    send_op(ptb_pkg::OP_START, 32'd0, 8'd1);
    send_op(ptb_pkg::OP_TICK, 32'd0, 8'd0);
    // Fill the bank, the largest timeout among the rest.
    send_op(ptb_pkg::OP_REGISTER, 32'hFFFF_FFFF, 8'd0);
    send_op(ptb_pkg::OP_REGISTER, 32'd3, 8'd0);
    send_op(ptb_pkg::OP_REGISTER, 32'd2, 8'd0);
    send_op(ptb_pkg::OP_REGISTER, 32'd5, 8'd0);
    send_op(ptb_pkg::OP_REGISTER, 32'hA5A5_A5A5, 8'd0);
    send_op(ptb_pkg::OP_REGISTER, 32'd4, 8'd0);
    // A ninth register finds the bank full.
    send_op(ptb_pkg::OP_REGISTER, 32'd7, 8'd0);
    // Run most timers, including the zero-timeout one, and let them count.
    send_op(ptb_pkg::OP_START, 32'd0, 8'd0);
    send_op(ptb_pkg::OP_START, 32'd0, 8'd2);
    send_op(ptb_pkg::OP_START, 32'd0, 8'd3);
    send_op(ptb_pkg::OP_START, 32'd0, 8'd4);
    send_op(ptb_pkg::OP_START, 32'd0, 8'd7);
    repeat (4) send_op(ptb_pkg::OP_TICK, 32'd0, 8'd0);

    // Random part in four idling phases: none, sender idle, receiver
    // stalling, and both together.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      repeat (ITEMS_PER_PH) send_random_op();
    end
    cmd_ch.valid = 1'b0;

    // Drain every expected word, then give the bank time to show any
    // stray result.
    while (book.due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    $display("Sent %0d operation words (%0d ticks), checked %0d result words.",
             words_sent, book.ticks_seen, words_checked);
    $display("Covered %0d expiries, %0d bank-full replies, %0d bad-index replies.",
             book.expiries_seen, book.full_seen, book.bad_index_seen);
    if (book.errors == 0) begin
      $display("periodic_timer_bank test passed");
    end else begin
      $display("periodic_timer_bank test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ptb_pkg.sv
hdl/ptb_if.sv
hdl/ptb_ram.sv
hdl/ptb_tick_unit.sv
hdl/periodic_timer_bank.sv
verif/tb_periodic_timer_bank.sv
